// ----- rtl/slpl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpl_pkg
// Shared constants and types for the packet link endpoint on a shared
// busy line.
// ----------------------------------------------------------------------------
package slpl_pkg;

  localparam int MAX_PACKET  = 20;
  localparam int MAX_PAYLOAD = 16;

  localparam int RX_IDX_W = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
  localparam int RX_CNT_W = $clog2(MAX_PACKET + 1);
  localparam int TX_IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int TX_CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int SEQ_W    = $clog2(MAX_PACKET + MAX_PAYLOAD + 4);

  localparam int MIN_FRAME = 4;
  localparam int HDR_BYTES = 3;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    OP_RX_BYTE   = 3'd0,
    OP_LINE_BUSY = 3'd1,
    OP_LINE_FREE = 3'd2,
    OP_LOAD_BYTE = 3'd3,
    OP_SEND      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_TX_BYTE  = 2'd0,
    KIND_RX_BYTE  = 2'd1,
    KIND_RX_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_OWN_ADDR  = 2'd0,
    REG_BCAST     = 2'd1,
    REG_ANNOUNCE  = 2'd2,
    REG_NAK_FLAGS = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_SUM  = 3'd1,
    S_RX   = 3'd2,
    S_NAK  = 3'd3,
    S_TX   = 3'd4
  } state_t;

endpackage

// ----- rtl/shared_line_packet_link_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_line_packet_link_top
// Packet link endpoint: buffers received frames, checks them when the line
// goes free, delivers payload, answers address claims and sends frames.
// ----------------------------------------------------------------------------
// Receive byte, line busy, payload load and a send request while the line is
// busy are handled in the idle state. A line free event starts a checksum pass
// over the buffered bytes when four or more bytes are buffered, then the result
// transfers, and then any pending frame of at most 15 payload bytes. A send
// request on a free line emits the header, the payload and the checksum. The
// single 8-bit adder steps over one buffered or emitted byte per cycle, the
// emitted bytes only while the output is not stalled.
module shared_line_packet_link_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[2:0], data_byte[10:3], dest_addr[18:11], tx_flags[26:19],
  // tx_length[31:27]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // data[7:0], source_addr[15:8], rx_flags[23:16]
  output logic [23:0] out_tdata,
  // kind[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  slpl_pkg::state_t state_r, state_nxt;

  logic [7:0] own_addr_r, bcast_r, announce_r, nak_flags_r;

  logic [7:0] rx_buf_r [slpl_pkg::MAX_PACKET];
  logic [7:0] tx_buf_r [slpl_pkg::MAX_PAYLOAD];

  logic [slpl_pkg::RX_CNT_W-1:0] rx_cnt_r, rx_cnt_nxt;
  logic [slpl_pkg::TX_CNT_W-1:0] tx_ld_cnt_r, tx_ld_cnt_nxt;
  logic [7:0] tx_dst_r, tx_dst_nxt, tx_src_r, tx_src_nxt, tx_flg_r, tx_flg_nxt;
  logic [slpl_pkg::TX_IDX_W-1:0] tx_len_r, tx_len_nxt;
  logic tx_pend_r, tx_pend_nxt;
  logic line_free_r, line_free_nxt;

  logic [slpl_pkg::SEQ_W-1:0] idx_r, idx_nxt, work_cnt_r, work_cnt_nxt;
  logic [7:0] sum_r, sum_nxt;

  logic        out_vld_r, out_vld_nxt;
  logic [7:0]  out_data_r, out_data_nxt, out_src_r, out_src_nxt, out_flg_r, out_flg_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic        out_last_r, out_last_nxt;

  slpl_pkg::op_t in_op;
  logic [7:0]  in_byte, in_dest, in_flags;
  logic [4:0]  in_len;
  logic        in_fire, send_ok, can_emit;
  logic        rx_we, tx_we;

  logic [7:0]  rx_rd, tx_rd, add_b, add_res, emit_byte;
  logic [slpl_pkg::SEQ_W-1:0] tx_off, tx_end;
  logic        sum_last, chk_ok, nak_hit, rx_hit;
  logic        rx_done, nak_done, tx_done;

  assign in_op    = slpl_pkg::op_t'(in_tdata[2:0]);
  assign in_byte  = in_tdata[10:3];
  assign in_dest  = in_tdata[18:11];
  assign in_flags = in_tdata[26:19];
  assign in_len   = in_tdata[31:27];

  assign in_tready = (state_r == slpl_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign send_ok   = (32'(in_len) < 32'(slpl_pkg::MAX_PAYLOAD));
  assign can_emit  = !out_vld_r || out_tready;

  assign rx_rd   = rx_buf_r[idx_r[slpl_pkg::RX_IDX_W-1:0]];
  assign tx_off  = idx_r - slpl_pkg::SEQ_W'(slpl_pkg::HDR_BYTES);
  assign tx_rd   = tx_buf_r[tx_off[slpl_pkg::TX_IDX_W-1:0]];
  assign tx_end  = slpl_pkg::SEQ_W'(tx_len_r) + slpl_pkg::SEQ_W'(slpl_pkg::HDR_BYTES);

  assign sum_last = (idx_r == work_cnt_r - slpl_pkg::SEQ_W'(1));
  assign chk_ok   = (sum_r == rx_rd);
  assign nak_hit  = (rx_buf_r[0] == bcast_r) && ((rx_buf_r[2] & announce_r) != 8'd0)
                    && (rx_buf_r[1] == own_addr_r);
  assign rx_hit   = (rx_buf_r[0] != bcast_r) && (rx_buf_r[0] == own_addr_r);

  assign rx_done  = (work_cnt_r == slpl_pkg::SEQ_W'(slpl_pkg::MIN_FRAME)) ||
                    (idx_r == work_cnt_r - slpl_pkg::SEQ_W'(2));
  assign nak_done = (idx_r == slpl_pkg::SEQ_W'(3));
  assign tx_done  = (idx_r == tx_end);

  always_comb begin
    unique case (idx_r)
      slpl_pkg::SEQ_W'(0): emit_byte = (state_r == slpl_pkg::S_NAK) ? bcast_r : tx_dst_r;
      slpl_pkg::SEQ_W'(1): emit_byte = (state_r == slpl_pkg::S_NAK) ? own_addr_r : tx_src_r;
      slpl_pkg::SEQ_W'(2): emit_byte = (state_r == slpl_pkg::S_NAK) ? nak_flags_r : tx_flg_r;
      default: begin
        if ((state_r == slpl_pkg::S_NAK) || tx_done) begin
          emit_byte = sum_r;
        end else begin
          emit_byte = tx_rd;
        end
      end
    endcase
  end

  // The one shared adder: checksum over buffered or emitted bytes.
  assign add_b   = (state_r == slpl_pkg::S_SUM) ? rx_rd : emit_byte;
  assign add_res = sum_r + add_b;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slpl_pkg::S_IDLE: begin
        if (in_fire && (in_op == slpl_pkg::OP_LINE_FREE)) begin
          if (32'(rx_cnt_r) >= slpl_pkg::MIN_FRAME) begin
            state_nxt = slpl_pkg::S_SUM;
          end else if (tx_pend_r) begin
            state_nxt = slpl_pkg::S_TX;
          end
        end else if (in_fire && (in_op == slpl_pkg::OP_SEND)) begin
          if (line_free_r && (send_ok || tx_pend_r)) begin
            state_nxt = slpl_pkg::S_TX;
          end
        end
      end
      slpl_pkg::S_SUM: begin
        if (sum_last) begin
          if (chk_ok && nak_hit) begin
            state_nxt = slpl_pkg::S_NAK;
          end else if (chk_ok && rx_hit) begin
            state_nxt = slpl_pkg::S_RX;
          end else if (tx_pend_r) begin
            state_nxt = slpl_pkg::S_TX;
          end else begin
            state_nxt = slpl_pkg::S_IDLE;
          end
        end
      end
      slpl_pkg::S_RX, slpl_pkg::S_NAK: begin
        if (can_emit && (((state_r == slpl_pkg::S_RX) && rx_done) ||
                         ((state_r == slpl_pkg::S_NAK) && nak_done))) begin
          state_nxt = tx_pend_r ? slpl_pkg::S_TX : slpl_pkg::S_IDLE;
        end
      end
      slpl_pkg::S_TX: begin
        if (can_emit && tx_done) begin
          state_nxt = slpl_pkg::S_IDLE;
        end
      end
      default: state_nxt = slpl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rx_cnt_nxt    = rx_cnt_r;
    tx_ld_cnt_nxt = tx_ld_cnt_r;
    tx_dst_nxt    = tx_dst_r;
    tx_src_nxt    = tx_src_r;
    tx_flg_nxt    = tx_flg_r;
    tx_len_nxt    = tx_len_r;
    tx_pend_nxt   = tx_pend_r;
    line_free_nxt = line_free_r;
    idx_nxt       = idx_r;
    work_cnt_nxt  = work_cnt_r;
    sum_nxt       = sum_r;
    rx_we         = 1'b0;
    tx_we         = 1'b0;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_src_nxt   = out_src_r;
    out_flg_nxt   = out_flg_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      slpl_pkg::S_IDLE: begin
        idx_nxt = '0;
        sum_nxt = '0;
        if (in_fire) begin
          unique case (in_op)
            slpl_pkg::OP_RX_BYTE: begin
              if (32'(rx_cnt_r) < slpl_pkg::MAX_PACKET) begin
                rx_we      = 1'b1;
                rx_cnt_nxt = rx_cnt_r + slpl_pkg::RX_CNT_W'(1);
              end
            end
            slpl_pkg::OP_LINE_BUSY: begin
              line_free_nxt = 1'b0;
              rx_cnt_nxt    = '0;
            end
            slpl_pkg::OP_LINE_FREE: begin
              line_free_nxt = 1'b1;
              work_cnt_nxt  = slpl_pkg::SEQ_W'(rx_cnt_r);
              rx_cnt_nxt    = '0;
            end
            slpl_pkg::OP_LOAD_BYTE: begin
              if (32'(tx_ld_cnt_r) < slpl_pkg::MAX_PAYLOAD) begin
                tx_we         = 1'b1;
                tx_ld_cnt_nxt = tx_ld_cnt_r + slpl_pkg::TX_CNT_W'(1);
              end
            end
            slpl_pkg::OP_SEND: begin
              if (send_ok) begin
                tx_dst_nxt    = in_dest;
                tx_src_nxt    = own_addr_r;
                tx_flg_nxt    = in_flags | {3'b000, in_len};
                tx_len_nxt    = slpl_pkg::TX_IDX_W'(in_len);
                tx_pend_nxt   = 1'b1;
                tx_ld_cnt_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      slpl_pkg::S_SUM: begin
        if (!sum_last) begin
          sum_nxt = add_res;
          idx_nxt = idx_r + slpl_pkg::SEQ_W'(1);
        end else begin
          sum_nxt = '0;
          idx_nxt = (chk_ok && !nak_hit && rx_hit) ? slpl_pkg::SEQ_W'(slpl_pkg::HDR_BYTES)
                                                   : '0;
        end
      end
      slpl_pkg::S_RX: begin
        if (can_emit) begin
          out_vld_nxt = 1'b1;
          out_src_nxt = rx_buf_r[1];
          out_flg_nxt = rx_buf_r[2];
          out_last_nxt = rx_done && !tx_pend_r;
          if (work_cnt_r == slpl_pkg::SEQ_W'(slpl_pkg::MIN_FRAME)) begin
            out_kind_nxt = slpl_pkg::KIND_RX_EMPTY;
            out_data_nxt = '0;
          end else begin
            out_kind_nxt = slpl_pkg::KIND_RX_BYTE;
            out_data_nxt = rx_rd;
          end
          idx_nxt = rx_done ? '0 : idx_r + slpl_pkg::SEQ_W'(1);
        end
      end
      slpl_pkg::S_NAK, slpl_pkg::S_TX: begin
        if (can_emit) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = slpl_pkg::KIND_TX_BYTE;
          out_data_nxt = emit_byte;
          out_src_nxt  = '0;
          out_flg_nxt  = '0;
          if (state_r == slpl_pkg::S_NAK) begin
            out_last_nxt = nak_done && !tx_pend_r;
            sum_nxt      = nak_done ? '0 : add_res;
            idx_nxt      = nak_done ? '0 : idx_r + slpl_pkg::SEQ_W'(1);
          end else begin
            out_last_nxt = tx_done;
            sum_nxt      = add_res;
            idx_nxt      = idx_r + slpl_pkg::SEQ_W'(1);
            if (tx_done) begin
              tx_pend_nxt = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slpl_pkg::S_IDLE;
      own_addr_r  <= 8'd0;
      bcast_r     <= 8'd255;
      announce_r  <= 8'd128;
      nak_flags_r <= 8'd64;
      rx_cnt_r    <= '0;
      tx_ld_cnt_r <= '0;
      tx_dst_r    <= '0;
      tx_src_r    <= '0;
      tx_flg_r    <= '0;
      tx_len_r    <= '0;
      tx_pend_r   <= 1'b0;
      line_free_r <= 1'b1;
      idx_r       <= '0;
      work_cnt_r  <= '0;
      sum_r       <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      tx_ld_cnt_r <= tx_ld_cnt_nxt;
      tx_dst_r    <= tx_dst_nxt;
      tx_src_r    <= tx_src_nxt;
      tx_flg_r    <= tx_flg_nxt;
      tx_len_r    <= tx_len_nxt;
      tx_pend_r   <= tx_pend_nxt;
      line_free_r <= line_free_nxt;
      idx_r       <= idx_nxt;
      work_cnt_r  <= work_cnt_nxt;
      sum_r       <= sum_nxt;
      out_vld_r   <= out_vld_nxt;
      if (cfg_we) begin
        unique case (slpl_pkg::reg_idx_t'(cfg_addr))
          slpl_pkg::REG_OWN_ADDR:  own_addr_r  <= cfg_wdata;
          slpl_pkg::REG_BCAST:     bcast_r     <= cfg_wdata;
          slpl_pkg::REG_ANNOUNCE:  announce_r  <= cfg_wdata;
          slpl_pkg::REG_NAK_FLAGS: nak_flags_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_src_r  <= out_src_nxt;
    out_flg_r  <= out_flg_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    if (rx_we) begin
      rx_buf_r[rx_cnt_r[slpl_pkg::RX_IDX_W-1:0]] <= in_byte;
    end
    if (tx_we) begin
      tx_buf_r[tx_ld_cnt_r[slpl_pkg::TX_IDX_W-1:0]] <= in_byte;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_flg_r, out_src_r, out_data_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_rx_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rx_cnt_r) <= slpl_pkg::MAX_PACKET)
    else $error("receive count beyond buffer size");

  a_tx_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slpl_pkg::S_TX) |-> tx_pend_r)
    else $error("transmit sequence without a pending frame");

  a_sum_min_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slpl_pkg::S_SUM) |-> (work_cnt_r >= slpl_pkg::SEQ_W'(slpl_pkg::MIN_FRAME)))
    else $error("checksum pass on a short frame");

  a_tx_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == slpl_pkg::S_TX) && can_emit && tx_done) |=>
      (!tx_pend_r && out_tvalid && out_tlast))
    else $error("frame end did not close the run");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packet link endpoint. Stimulus drives received
// frames, line busy and line free events, payload loads and send requests.
// A predictor inside the bench computes the bytes driven on the line and
// the payload it delivers, and every result transfer is compared with them.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 64;
  localparam int PHASE_ITEMS  = 12;

  typedef struct packed {
    slpl_pkg::kind_t kind;
    logic [7:0]      data;
    logic [7:0]      src;
    logic [7:0]      flags;
    logic            last;
  } link_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [7:0]  cfg_wdata = '0;

  shared_line_packet_link_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Link state as the block should hold it.
  logic [7:0]  link_own = 8'd0;
  logic [7:0]  link_bcast = 8'd255;
  logic [7:0]  link_announce = 8'd128;
  logic [7:0]  link_nak = 8'd64;
  logic [7:0]  rx_frame_buf [slpl_pkg::MAX_PACKET];
  int          rx_held = 0;
  logic [7:0]  tx_payload [slpl_pkg::MAX_PAYLOAD];
  int          tx_loaded = 0;
  int          tx_filled = 0;
  logic [23:0] tx_hdr = '0;
  int          tx_len = 0;
  bit          tx_pend = 1'b0;
  bit          line_is_free = 1'b1;

  link_result_t link_results_q [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int n_transfers = 0;
  int n_results = 0;
  int n_settings = 0;
  int cycle_count = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, link_results_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void report_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic void push_result(slpl_pkg::kind_t kind, logic [7:0] data,
                                      logic [7:0] src, logic [7:0] flags);
    link_result_t r;
    r.kind = kind;
    r.data = data;
    r.src = src;
    r.flags = flags;
    r.last = 1'b0;
    link_results_q.push_back(r);
  endfunction

  function automatic void check_frame();
    logic [7:0] sum;
    logic [7:0] src;
    logic [7:0] flags;
    int i;
    sum = '0;
    if (rx_held >= 4 && rx_held <= slpl_pkg::MAX_PACKET) begin
      for (i = 0; i < rx_held - 1; i++) sum = sum + rx_frame_buf[i];
      src = rx_frame_buf[1];
      flags = rx_frame_buf[2];
      if (sum == rx_frame_buf[rx_held - 1]) begin
        if (rx_frame_buf[0] == link_bcast) begin
          if ((flags & link_announce) != 0 && src == link_own) begin
            push_result(slpl_pkg::KIND_TX_BYTE, link_bcast, 8'd0, 8'd0);
            push_result(slpl_pkg::KIND_TX_BYTE, link_own, 8'd0, 8'd0);
            push_result(slpl_pkg::KIND_TX_BYTE, link_nak, 8'd0, 8'd0);
            push_result(slpl_pkg::KIND_TX_BYTE, link_bcast + link_own + link_nak,
                        8'd0, 8'd0);
          end
        end else if (rx_frame_buf[0] == link_own) begin
          if (rx_held == 4) begin
            push_result(slpl_pkg::KIND_RX_EMPTY, 8'd0, src, flags);
          end else begin
            for (i = 3; i < rx_held - 1; i++)
              push_result(slpl_pkg::KIND_RX_BYTE, rx_frame_buf[i], src, flags);
          end
        end
      end
    end
    rx_held = 0;
  endfunction

  function automatic void flush_tx();
    logic [7:0] sum;
    int i;
    if (tx_pend) begin
      sum = tx_hdr[23:16] + tx_hdr[15:8] + tx_hdr[7:0];
      push_result(slpl_pkg::KIND_TX_BYTE, tx_hdr[23:16], 8'd0, 8'd0);
      push_result(slpl_pkg::KIND_TX_BYTE, tx_hdr[15:8], 8'd0, 8'd0);
      push_result(slpl_pkg::KIND_TX_BYTE, tx_hdr[7:0], 8'd0, 8'd0);
      for (i = 0; i < tx_len; i++) begin
        sum = sum + tx_payload[i];
        push_result(slpl_pkg::KIND_TX_BYTE, tx_payload[i], 8'd0, 8'd0);
      end
      push_result(slpl_pkg::KIND_TX_BYTE, sum, 8'd0, 8'd0);
      tx_pend = 1'b0;
    end
  endfunction

  function automatic void step_link(logic [2:0] op, logic [7:0] data, logic [7:0] dest,
                                    logic [7:0] flags, logic [4:0] len);
    int q_start;
    int idx;
    link_result_t r;
    q_start = link_results_q.size();
    case (op)
      slpl_pkg::OP_RX_BYTE: begin
        if (rx_held < slpl_pkg::MAX_PACKET) begin
          rx_frame_buf[rx_held] = data;
          rx_held++;
        end
      end
      slpl_pkg::OP_LINE_BUSY: begin
        line_is_free = 1'b0;
        rx_held = 0;
      end
      slpl_pkg::OP_LINE_FREE: begin
        line_is_free = 1'b1;
        check_frame();
        flush_tx();
      end
      slpl_pkg::OP_LOAD_BYTE: begin
        if (tx_loaded < slpl_pkg::MAX_PAYLOAD) begin
          tx_payload[tx_loaded] = data;
          tx_loaded++;
          if (tx_loaded > tx_filled) tx_filled = tx_loaded;
        end
      end
      slpl_pkg::OP_SEND: begin
        if (int'(len) < slpl_pkg::MAX_PAYLOAD) begin
          tx_hdr = {dest, link_own, flags | {3'b000, len}};
          tx_len = int'(len);
          tx_pend = 1'b1;
          tx_loaded = 0;
        end
        if (line_is_free) flush_tx();
      end
      default: begin
      end
    endcase
    if (link_results_q.size() > q_start) begin
      idx = link_results_q.size() - 1;
      r = link_results_q[idx];
      r.last = 1'b1;
      link_results_q[idx] = r;
    end
  endfunction

  always @(posedge clk) begin
    link_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (link_results_q.size() == 0) begin
        report_error($sformatf("unexpected result kind %0d data %02h src %02h flags %02h",
                               out_tuser, out_tdata[7:0], out_tdata[15:8],
                               out_tdata[23:16]));
      end else begin
        exp_r = link_results_q.pop_front();
        if (out_tuser !== exp_r.kind || out_tdata[7:0] !== exp_r.data ||
            out_tdata[15:8] !== exp_r.src || out_tdata[23:16] !== exp_r.flags ||
            out_tlast !== exp_r.last) begin
          report_error($sformatf(
            "expected kind %0d data %02h src %02h flags %02h last %0b, got %0d %02h %02h %02h %0b",
            exp_r.kind, exp_r.data, exp_r.src, exp_r.flags, exp_r.last, out_tuser,
            out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tlast));
        end
      end
    end
  end

  task automatic send_item(input logic [2:0] op, input logic [7:0] data,
                           input logic [7:0] dest, input logic [7:0] flags,
                           input logic [4:0] len);
    int gap;
    gap = 0;
    while (gap < 64 && $urandom_range(99) < idle_pct) gap++;
    @(negedge clk);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {len, flags, dest, data, op};
    do @(posedge clk); while (!in_tready);
    n_transfers++;
    step_link(op, data, dest, flags, len);
  endtask

  task automatic rx_byte(input logic [7:0] b);
    send_item(slpl_pkg::OP_RX_BYTE, b, 8'($urandom), 8'($urandom), 5'($urandom));
  endtask

  task automatic line_event(input logic [2:0] op);
    send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (link_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] own, input logic [7:0] bcast,
                          input logic [7:0] announce, input logic [7:0] nak);
    logic [7:0] vals [4];
    int i;
    vals[0] = own;
    vals[1] = bcast;
    vals[2] = announce;
    vals[3] = nak;
    for (i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= i[1:0];
      cfg_wdata <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    link_own = own;
    link_bcast = bcast;
    link_announce = announce;
    link_nak = nak;
    n_settings++;
  endtask

  function automatic logic [4:0] pick_length();
    if ($urandom_range(9) == 0) return 5'($urandom_range(16, 31));
    return 5'($urandom_range(0, tx_filled));
  endfunction

  // Reset defaults: own address 0, broadcast 255, announce bit 7, NAK flags 64.
  task automatic test_transmit();
    send_item(slpl_pkg::OP_LOAD_BYTE, 8'h00, 8'hFF, 8'hFF, 5'd31);
    send_item(slpl_pkg::OP_LOAD_BYTE, 8'hFF, 8'h00, 8'h00, 5'd0);
    send_item(slpl_pkg::OP_SEND, 8'h00, 8'hFF, 8'h00, 5'd2);
    send_item(slpl_pkg::OP_SEND, 8'hFF, 8'h00, 8'hFF, 5'd31);
    wait_idle();
  endtask

  task automatic test_announce();
    line_event(slpl_pkg::OP_LINE_BUSY);
    send_item(slpl_pkg::OP_SEND, 8'h00, 8'h12, 8'h80, 5'd1);
    rx_byte(8'hFF);
    rx_byte(8'h00);
    rx_byte(8'h80);
    rx_byte(8'h7F);
    line_event(slpl_pkg::OP_LINE_FREE);
    wait_idle();
  endtask

  task automatic test_receive();
    line_event(slpl_pkg::OP_LINE_BUSY);
    rx_byte(8'h00);
    rx_byte(8'hFF);
    rx_byte(8'hFF);
    rx_byte(8'hFF);
    rx_byte(8'hFD);
    line_event(slpl_pkg::OP_LINE_FREE);
    rx_byte(8'h00);
    rx_byte(8'h01);
    rx_byte(8'h10);
    rx_byte(8'h11);
    line_event(slpl_pkg::OP_LINE_FREE);
    wait_idle();
  endtask

  task automatic test_unknown_ops();
    send_item(3'd5, 8'hFF, 8'hFF, 8'hFF, 5'd31);
    send_item(3'd6, 8'h00, 8'h00, 8'h00, 5'd0);
    send_item(3'd7, 8'hFF, 8'hFF, 8'hFF, 5'd31);
    wait_idle();
  endtask

  task automatic rx_frame_random();
    logic [7:0] dest;
    logic [7:0] src;
    logic [7:0] flags;
    logic [7:0] sum;
    logic [7:0] b;
    int sel;
    int n_pay;
    int i;
    sel = $urandom_range(99);
    if (sel < 40) dest = link_own;
    else if (sel < 65) dest = link_bcast;
    else dest = 8'($urandom);
    src = $urandom_range(1) ? link_own : 8'($urandom);
    flags = 8'($urandom);
    if ($urandom_range(4) != 0) line_event(slpl_pkg::OP_LINE_BUSY);
    sel = $urandom_range(9);
    if (sel == 0) begin
      repeat ($urandom_range(0, 3)) rx_byte(8'($urandom));
      line_event(slpl_pkg::OP_LINE_FREE);
    end else begin
      n_pay = (sel == 1) ? $urandom_range(17, 20) : $urandom_range(0, 16);
      rx_byte(dest);
      rx_byte(src);
      rx_byte(flags);
      sum = dest + src + flags;
      for (i = 0; i < n_pay; i++) begin
        b = 8'($urandom);
        sum = sum + b;
        rx_byte(b);
      end
      if ($urandom_range(9) == 0) sum = sum ^ (8'h01 << $urandom_range(7));
      rx_byte(sum);
      line_event(slpl_pkg::OP_LINE_FREE);
    end
  endtask

  task automatic tx_sequence_random();
    if ($urandom_range(2) == 0) line_event(slpl_pkg::OP_LINE_BUSY);
    repeat ($urandom_range(0, 18)) send_item(slpl_pkg::OP_LOAD_BYTE, 8'($urandom),
                                             8'($urandom), 8'($urandom), 5'($urandom));
    send_item(slpl_pkg::OP_SEND, 8'($urandom), 8'($urandom), 8'($urandom),
              pick_length());
  endtask

  task automatic noise_item();
    logic [2:0] op;
    op = 3'($urandom_range(0, 7));
    if (op == slpl_pkg::OP_SEND) begin
      send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), pick_length());
    end else begin
      send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
    end
  endtask

  task automatic test_random(input int in_idle, input int out_stall);
    int start;
    int sel;
    idle_pct = in_idle;
    stall_pct = out_stall;
    start = n_transfers;
    while (n_transfers - start < PHASE_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 50) rx_frame_random();
      else if (sel < 80) tx_sequence_random();
      else noise_item();
    end
    if (!line_is_free) line_event(slpl_pkg::OP_LINE_FREE);
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_transmit();
    test_announce();
    test_receive();
    test_unknown_ops();

    set_regs(8'h00, 8'hFF, 8'hFF, 8'h00);
    test_random(0, 0);
    set_regs(8'hFF, 8'h00, 8'h01, 8'hFF);
    test_random(74, 0);
    set_regs(8'h3C, 8'hFF, 8'h80, 8'h40);
    test_random(0, 74);
    set_regs(8'hFF, 8'hFF, 8'h00, 8'hA5);
    test_random(25, 25);

    if (link_results_q.size() != 0)
      report_error($sformatf("%0d results never arrived", link_results_q.size()));
    $display("Sent %0d input transfers and checked %0d result transfers.",
             n_transfers, n_results);
    $display("Covered %0d register settings, four handshake pacing modes, %0d mismatches.",
             n_settings, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- shared_line_packet_link_top.f -----
rtl/slpl_pkg.sv
rtl/shared_line_packet_link_top.sv
dv/tb.sv
